// ===== hdl/pwhc_pkg.sv =====
// package for the pilot wire heater controller
// holds sizes, mode and request codes, shared structs and the phase length function
// no dependencies
package pwhc_pkg;

	localparam int HEATER_COUNT = 4;
	localparam int MS_W = 19;
	localparam int MS_IN_SEC = 1000;
	localparam int BITS_W = 4;

	typedef logic [2:0] mode_t;
	typedef logic [1:0] req_t;
	typedef logic [1:0] cfg_idx_t;
	typedef logic [MS_W-1:0] ms_t;

	// heater modes
	localparam mode_t MODE_COMFORT = 3'd0;
	localparam mode_t MODE_MIN1    = 3'd1;
	localparam mode_t MODE_MIN2    = 3'd2;
	localparam mode_t MODE_ECO     = 3'd3;
	localparam mode_t MODE_FROST   = 3'd4;
	localparam mode_t MODE_OFF     = 3'd5;

	// request types
	localparam req_t REQ_SET  = 2'd0;
	localparam req_t REQ_TICK = 2'd1;
	localparam req_t REQ_READ = 2'd2;

	// configuration register indexes
	localparam cfg_idx_t CFG_MIN1_ACTIVE = 2'd0;
	localparam cfg_idx_t CFG_MIN2_ACTIVE = 2'd1;
	localparam cfg_idx_t CFG_PERIOD      = 2'd2;

	// configuration reset values
	localparam ms_t MIN1_RESET   = MS_W'(3 * MS_IN_SEC);
	localparam ms_t MIN2_RESET   = MS_W'(7 * MS_IN_SEC);
	localparam ms_t PERIOD_RESET = MS_W'(300 * MS_IN_SEC);

	typedef struct packed {
		ms_t min1_active;
		ms_t min2_active;
		ms_t period;
	} cfg_t;

	// per heater command for one processed transaction
	typedef struct packed {
		logic  set_hit;
		logic  tick;
		mode_t mode;
	} heater_cmd_t;

	// length of the phase being entered in a timed mode
	function automatic ms_t phase_len(input mode_t m, input logic active, input cfg_t cfg);
		ms_t act;
		act = (m == MODE_MIN1) ? cfg.min1_active : cfg.min2_active;
		if (active)
			return act;
		return (cfg.period > act) ? ms_t'(cfg.period - act) : '0;
	endfunction

endpackage

// ===== hdl/pwhc_heater.sv =====
// state of one heater: mode, phase, countdown and the two output drives
// depends on pwhc_pkg
module pwhc_heater (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  pwhc_pkg::heater_cmd_t cmd,
	input  pwhc_pkg::cfg_t      cfg,
	output pwhc_pkg::mode_t     mode_cur,
	output logic                pos_next,
	output logic                neg_next
);
	import pwhc_pkg::*;

	mode_t mode_q, mode_d;
	logic  phase_q, phase_d;
	logic  pend_q, pend_d;
	ms_t   cd_q, cd_d;
	logic  pos_q, pos_d;
	logic  neg_q, neg_d;

	logic  changed;
	logic  timed;
	logic  cur_timed;
	logic  phase_base;

	// next state for a set or a tick
	always_comb begin
		mode_d  = mode_q;
		phase_d = phase_q;
		pend_d  = pend_q;
		cd_d    = cd_q;
		pos_d   = pos_q;
		neg_d   = neg_q;
		changed    = (mode_q != cmd.mode);
		timed      = (cmd.mode == MODE_MIN1) || (cmd.mode == MODE_MIN2);
		cur_timed  = (mode_q == MODE_MIN1) || (mode_q == MODE_MIN2);
		phase_base = changed ? 1'b0 : phase_q;
		if (step && cmd.set_hit) begin
			mode_d = cmd.mode;
			if (!timed) begin
				if (changed)
					pend_d = 1'b0;
			end
			case (cmd.mode)
				MODE_COMFORT: begin pos_d = 1'b0; neg_d = 1'b0; end
				MODE_ECO:     begin pos_d = 1'b1; neg_d = 1'b1; end
				MODE_FROST:   begin pos_d = 1'b0; neg_d = 1'b1; end
				MODE_OFF:     begin pos_d = 1'b1; neg_d = 1'b0; end
				default: begin
					phase_d = phase_base;
					if (!pend_q) begin
						// fire straight into the next phase
						phase_d = !phase_base;
						pos_d   = !phase_base;
						neg_d   = !phase_base;
						cd_d    = phase_len(cmd.mode, !phase_base, cfg);
						pend_d  = 1'b1;
					end
				end
			endcase
		end else if (step && cmd.tick && pend_q) begin
			if (cd_q <= ms_t'(1)) begin
				if (!cur_timed) begin
					pend_d = 1'b0;
				end else begin
					phase_d = !phase_q;
					pos_d   = !phase_q;
					neg_d   = !phase_q;
					cd_d    = phase_len(mode_q, !phase_q, cfg);
					pend_d  = 1'b1;
				end
			end else begin
				cd_d = ms_t'(cd_q - ms_t'(1));
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_OFF;
			phase_q <= 1'b0;
			pend_q  <= 1'b0;
			cd_q    <= '0;
			pos_q   <= 1'b1;
			neg_q   <= 1'b0;
		end else begin
			mode_q  <= mode_d;
			phase_q <= phase_d;
			pend_q  <= pend_d;
			cd_q    <= cd_d;
			pos_q   <= pos_d;
			neg_q   <= neg_d;
		end
	end

	assign mode_cur = mode_q;
	assign pos_next = pos_d;
	assign neg_next = neg_d;

endmodule

// ===== hdl/pilot_wire_heater_controller_core.sv =====
// Pilot wire heater controller, six modes over two open-collector phases.
//
// Input channel (in_valid/in_ready) carries one request per transaction:
// set mode, one millisecond tick, or read mode, with heater select and mode.
// Output channel (out_valid/out_ready) returns one result per request:
// status, the positive and negative drive bits after the request, and the
// mode read back.
// The request is captured in an input register when accepted and processed
// from there; its result is loaded into the result register, with out_valid
// high, when the input register advances.
// Throughput is one transaction per cycle while the receiver does not stall;
// every heater countdown updates in parallel on a tick, so no request waits on a sequence.
// When the receiver stalls, the result register holds and the input
// register keeps one further request; in_ready falls only when both are full.
// Reset puts every heater in off mode (positive drive on), clears timers and
// loads the configuration defaults: 3000, 7000 and 300000 ms.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are expected only while no transaction is in flight.
// depends on pwhc_pkg and pwhc_heater
module pilot_wire_heater_controller_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  pwhc_pkg::cfg_idx_t   cfg_index,
	input  pwhc_pkg::ms_t        cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pwhc_pkg::req_t       req_type,
	input  logic [2:0]           heater_sel,
	input  pwhc_pkg::mode_t      mode,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 status,
	output logic [3:0]           pos_active_bits,
	output logic [3:0]           neg_active_bits,
	output pwhc_pkg::mode_t      mode_read
);
	import pwhc_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	req_t        req_s1;
	logic [2:0]  idx_s1;
	mode_t       mode_s1;
	logic        out_valid_q;
	logic        status_q;
	logic [BITS_W-1:0] pos_q, neg_q;
	mode_t       mread_q;

	logic        advance;
	logic        idx_ok;
	logic        mode_ok;
	logic        status_d;
	mode_t       mread_d;
	mode_t       sel_mode;
	logic [BITS_W-1:0] pos_d, neg_d;

	mode_t       hmode [HEATER_COUNT];
	logic        hpos  [HEATER_COUNT];
	logic        hneg  [HEATER_COUNT];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min1_active <= MIN1_RESET;
			cfg_q.min2_active <= MIN2_RESET;
			cfg_q.period      <= PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN1_ACTIVE: cfg_q.min1_active <= cfg_data;
				CFG_MIN2_ACTIVE: cfg_q.min2_active <= cfg_data;
				CFG_PERIOD:      cfg_q.period      <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1  <= req_type;
			idx_s1  <= heater_sel;
			mode_s1 <= mode;
		end
	end

	assign idx_ok  = ({1'b0, idx_s1} < 4'(HEATER_COUNT));
	assign mode_ok = (mode_s1 <= MODE_OFF);

	// heaters
	for (genvar h = 0; h < HEATER_COUNT; h++) begin : g_heater
		heater_cmd_t cmd;
		assign cmd.set_hit = (req_s1 == REQ_SET) && idx_ok && mode_ok
			&& (idx_s1 == 3'(h));
		assign cmd.tick = (req_s1 == REQ_TICK);
		assign cmd.mode = mode_s1;
		pwhc_heater u_heater (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (advance),
			.cmd      (cmd),
			.cfg      (cfg_q),
			.mode_cur (hmode[h]),
			.pos_next (hpos[h]),
			.neg_next (hneg[h])
		);
	end

	// drive bits after the request and read back mux
	always_comb begin
		pos_d    = '0;
		neg_d    = '0;
		sel_mode = MODE_OFF;
		for (int h = 0; h < HEATER_COUNT; h++) begin
			pos_d[h] = hpos[h];
			neg_d[h] = hneg[h];
			if (idx_s1 == 3'(h))
				sel_mode = hmode[h];
		end
	end

	// status and mode read
	always_comb begin
		status_d = 1'b0;
		mread_d  = MODE_COMFORT;
		case (req_s1)
			REQ_SET:  status_d = !(idx_ok && mode_ok);
			REQ_TICK: status_d = 1'b0;
			REQ_READ: begin
				status_d = !idx_ok;
				mread_d  = idx_ok ? sel_mode : MODE_OFF;
			end
			default:  status_d = 1'b1;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			pos_q    <= pos_d;
			neg_q    <= neg_d;
			mread_q  <= mread_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign pos_active_bits = pos_q;
	assign neg_active_bits = neg_q;
	assign mode_read       = mread_q;

endmodule

// ===== hdl/pwhc_checker.sv =====
// port level checks for the pilot wire heater controller, bound to the top level
// depends on pwhc_pkg and pilot_wire_heater_controller_core
module pwhc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 status,
	input logic [3:0]           pos_active_bits,
	input logic [3:0]           neg_active_bits,
	input pwhc_pkg::mode_t      mode_read
);
	import pwhc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(pos_active_bits) && $stable(neg_active_bits) && $stable(mode_read))
		else $error("stalled result changed");

	// input side blocks only while a full result waits on the receiver
	a_ready_block: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked without output stall");

	// an error result reads back either nothing or off mode
	a_err_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> (mode_read == MODE_COMFORT) || (mode_read == MODE_OFF))
		else $error("bad mode read on error");

	// read back never shows an invalid mode code
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mode_read <= MODE_OFF)
		else $error("mode read out of range");

endmodule

bind pilot_wire_heater_controller_core pwhc_checker u_pwhc_checker (.*);
